/* src/cfd_pkg.sv */
// shared constants and types of the channel frame deframer
package cfd_pkg;

    localparam int unsigned LengthCounterBits = 19;
    localparam int unsigned MaxLengthBits     = 19;
    localparam int unsigned HeaderBytes       = 20;
    localparam int unsigned CfgDataBits       = 32;

    localparam logic [31:0] AbsMaxLen   = 32'd262144;
    localparam logic [31:0] CounterMax  = 32'((64'd1 << LengthCounterBits) - 64'd1);
    localparam logic [31:0] CtrlChannel = 32'hFFFF_FFFF;
    localparam logic [31:0] CmdKilled   = 32'd65;
    localparam logic [7:0]  TagLong     = 8'h4C;

    typedef enum logic [1:0] {
        EV_PAYLOAD = 2'd0,
        EV_BAD_LEN = 2'd1,
        EV_SERVER  = 2'd2,
        EV_KILLED  = 2'd3
    } t_event;

    typedef enum logic {
        CFG_STREAM_CHANNEL = 1'b0,
        CFG_MAX_LENGTH     = 1'b1
    } t_cfg_index;

endpackage

/* src/cfd_in_if.sv */
// input channel of the deframer: one raw link byte per item
interface cfd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] stream_byte;

    modport source (output valid, output stream_byte, input ready);
    modport sink (input valid, input stream_byte, output ready);
endinterface

/* src/cfd_out_if.sv */
// output channel of the deframer: payload byte or error event per item
interface cfd_out_if;
    logic              valid;
    logic              ready;
    logic [7:0]        data_byte;
    logic              last_in_frame;
    cfd_pkg::t_event   event_res;

    modport source (output valid, output data_byte, output last_in_frame,
                    output event_res, input ready);
    modport sink (input valid, input data_byte, input last_in_frame,
                  input event_res, output ready);
endinterface

/* src/channel_frame_deframer.sv */
// channel frame deframer: splits a framed link byte stream and passes one channel out
//
// i_in carries raw link bytes, o_out carries payload bytes of the selected stream
// channel (last_in_frame marks the frame end) or a single error event.
// Each frame has a 20-byte header (big-endian length, big-endian channel, 12 spare
// bytes). Frames on other channels are dropped; the control channel is parsed for
// an 'L' tag and a 32-bit command that can report server error or stream killed.
// Configuration goes through i_cfg_we / i_cfg_index / i_cfg_data; the user must write
// it only while idle, as the block does not enforce this. A result reaches o_out
// in the cycle after its byte is accepted; one byte per cycle unless o_out stalls.
// Header counter, length compare and control capture sit between i_in and r_out_*.
// Reset (synchronous, active low) returns to the header phase, clears the halt
// flag and loads stream_channel 0 and max_frame_length 262144.
// When o_out stalls with a result held, i_in.ready drops for every byte, even
// one that makes no result, until the result register frees.
// After any error event all further bytes are consumed silently until reset.
module channel_frame_deframer (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    cfd_in_if.sink                             i_in,
    cfd_out_if.source                          o_out,
    input  logic                               i_cfg_we,
    input  logic                               i_cfg_index,
    input  logic [cfd_pkg::CfgDataBits-1:0]    i_cfg_data
);

    typedef enum logic {
        PH_HEADER,
        PH_BODY
    } t_phase;

    localparam int unsigned LenBits    = cfd_pkg::LengthCounterBits;
    localparam int unsigned CfgLenBits = cfd_pkg::MaxLengthBits;

    t_phase               r_phase, n_phase;
    logic [4:0]           r_hdr_cnt, n_hdr_cnt;
    logic [31:0]          r_length, n_length;
    logic [31:0]          r_channel, n_channel;
    logic [LenBits-1:0]   r_remaining, n_remaining;
    logic [2:0]           r_ctrl_cnt, n_ctrl_cnt;
    logic                 r_tag_ok, n_tag_ok;
    logic [31:0]          r_command, n_command;
    logic                 r_halted, n_halted;

    logic [31:0]          r_stream_channel;
    logic [CfgLenBits-1:0] r_max_length;

    logic                 r_out_valid;
    logic [7:0]           r_out_data;
    logic                 r_out_last;
    cfd_pkg::t_event      r_out_event;

    logic                 n_res_valid;
    logic [7:0]           n_res_data;
    logic                 n_res_last;
    cfd_pkg::t_event      n_res_event;

    logic                 accept;
    logic [31:0]          limit;
    logic [31:0]          cmd_eff;
    logic                 done;
    logic [7:0]           b;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;
    assign b          = i_in.stream_byte;

    // effective limit: register value saturated at the absolute maximum
    always_comb begin
        limit = 32'(r_max_length);
        if (limit > cfd_pkg::AbsMaxLen) begin
            limit = cfd_pkg::AbsMaxLen;
        end
        if (limit > cfd_pkg::CounterMax) begin
            limit = cfd_pkg::CounterMax;
        end
    end

    always_comb begin
        n_phase     = r_phase;
        n_hdr_cnt   = r_hdr_cnt;
        n_length    = r_length;
        n_channel   = r_channel;
        n_remaining = r_remaining;
        n_ctrl_cnt  = r_ctrl_cnt;
        n_tag_ok    = r_tag_ok;
        n_command   = r_command;
        n_halted    = r_halted;
        n_res_valid = 1'b0;
        n_res_data  = 8'd0;
        n_res_last  = 1'b0;
        n_res_event = cfd_pkg::EV_PAYLOAD;
        cmd_eff     = 32'd0;
        done        = 1'b0;

        if (!r_halted) begin
            case (r_phase)
                PH_HEADER: begin
                    if (r_hdr_cnt < 5'd4) begin
                        n_length = {r_length[23:0], b};
                    end else if (r_hdr_cnt < 5'd8) begin
                        n_channel = {r_channel[23:0], b};
                    end
                    n_hdr_cnt = r_hdr_cnt + 5'd1;
                    if (r_hdr_cnt == 5'(cfd_pkg::HeaderBytes - 1)) begin
                        n_hdr_cnt = 5'd0;
                        if (r_length == 32'd0 || r_length > limit) begin
                            n_halted    = 1'b1;
                            n_res_valid = 1'b1;
                            n_res_event = cfd_pkg::EV_BAD_LEN;
                        end else begin
                            n_remaining = r_length[LenBits-1:0];
                            n_ctrl_cnt  = 3'd0;
                            n_tag_ok    = 1'b0;
                            n_command   = 32'd0;
                            n_phase     = PH_BODY;
                        end
                    end
                end
                PH_BODY: begin
                    n_remaining = r_remaining - LenBits'(1);
                    done        = (n_remaining == '0);
                    if (done) begin
                        n_phase = PH_HEADER;
                    end
                    if (r_channel == cfd_pkg::CtrlChannel) begin
                        if (r_ctrl_cnt == 3'd0) begin
                            n_tag_ok   = (b == cfd_pkg::TagLong);
                            n_ctrl_cnt = 3'd1;
                        end else if (r_ctrl_cnt < 3'd5) begin
                            n_command  = {r_command[23:0], b};
                            n_ctrl_cnt = r_ctrl_cnt + 3'd1;
                        end
                        cmd_eff = (n_ctrl_cnt == 3'd5 && n_tag_ok) ? n_command : 32'd0;
                        if (done) begin
                            if (cmd_eff == 32'd0) begin
                                n_halted    = 1'b1;
                                n_res_valid = 1'b1;
                                n_res_event = cfd_pkg::EV_SERVER;
                            end else if (cmd_eff == cfd_pkg::CmdKilled) begin
                                n_halted    = 1'b1;
                                n_res_valid = 1'b1;
                                n_res_event = cfd_pkg::EV_KILLED;
                            end
                        end
                    end else if (r_channel == r_stream_channel) begin
                        n_res_valid = 1'b1;
                        n_res_data  = b;
                        n_res_last  = done;
                    end
                end
                default: begin
                    n_phase = PH_HEADER;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase          <= PH_HEADER;
            r_hdr_cnt        <= 5'd0;
            r_length         <= 32'd0;
            r_channel        <= 32'd0;
            r_remaining      <= '0;
            r_ctrl_cnt       <= 3'd0;
            r_tag_ok         <= 1'b0;
            r_command        <= 32'd0;
            r_halted         <= 1'b0;
            r_stream_channel <= 32'd0;
            r_max_length     <= CfgLenBits'(cfd_pkg::AbsMaxLen);
            r_out_valid      <= 1'b0;
        end else begin
            if (accept) begin
                r_phase     <= n_phase;
                r_hdr_cnt   <= n_hdr_cnt;
                r_length    <= n_length;
                r_channel   <= n_channel;
                r_remaining <= n_remaining;
                r_ctrl_cnt  <= n_ctrl_cnt;
                r_tag_ok    <= n_tag_ok;
                r_command   <= n_command;
                r_halted    <= n_halted;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    cfd_pkg::CFG_STREAM_CHANNEL: r_stream_channel <= i_cfg_data;
                    cfd_pkg::CFG_MAX_LENGTH:     r_max_length <= i_cfg_data[CfgLenBits-1:0];
                    default: begin
                    end
                endcase
            end
            if (accept && n_res_valid) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload, loaded only with a new result
    always_ff @(posedge i_clk) begin
        if (accept && n_res_valid) begin
            r_out_data  <= n_res_data;
            r_out_last  <= n_res_last;
            r_out_event <= n_res_event;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.data_byte     = r_out_data;
    assign o_out.last_in_frame = r_out_last;
    assign o_out.event_res     = r_out_event;

endmodule

/* tb/sv/channel_frame_deframer_tb.sv */
// self-checking testbench of the channel frame deframer with its own byte-level predictor
module channel_frame_deframer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [7:0]      data;
        logic            last;
        cfd_pkg::t_event ev;
    } t_deframe_result;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_cfg_we;
    logic                            i_cfg_index;
    logic [cfd_pkg::CfgDataBits-1:0] i_cfg_data;

    cfd_in_if  in_if();
    cfd_out_if out_if();

    channel_frame_deframer uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    // predictor copy of the registers and the parser state
    logic [31:0] stream_chan = 32'd0;
    logic [cfd_pkg::MaxLengthBits-1:0] max_len = cfd_pkg::MaxLengthBits'(cfd_pkg::AbsMaxLen);
    bit          in_body     = 1'b0;
    logic [4:0]  hdr_count   = 5'd0;
    logic [31:0] frame_len   = 32'd0;
    logic [31:0] frame_chan  = 32'd0;
    logic [31:0] body_left   = 32'd0;
    logic [2:0]  ctrl_count  = 3'd0;
    bit          ctrl_tag_ok = 1'b0;
    logic [31:0] ctrl_cmd    = 32'd0;
    bit          halted      = 1'b0;

    t_deframe_result expected_results[$];
    logic [7:0]      pending_bytes[$];

    int unsigned issued_bytes   = 0;
    int unsigned accepted_bytes = 0;
    int unsigned results_seen   = 0;
    int unsigned fault_count    = 0;
    bit          in_idle_on     = 1'b1;
    bit          out_idle_on    = 1'b1;

    function automatic logic [31:0] length_limit();
        logic [31:0] lim;
        lim = 32'(max_len);
        if (lim > cfd_pkg::AbsMaxLen) lim = cfd_pkg::AbsMaxLen;
        if (lim > cfd_pkg::CounterMax) lim = cfd_pkg::CounterMax;
        return lim;
    endfunction

    // advances the parser by one link byte, returns 1 when a result is due
    function automatic bit deframe_byte(input logic [7:0] b, output t_deframe_result res);
        logic [31:0] cmd;
        bit          done;
        res = '{8'h00, 1'b0, cfd_pkg::EV_PAYLOAD};
        if (halted) return 1'b0;

        if (!in_body) begin
            if (hdr_count < 4) frame_len = {frame_len[23:0], b};
            else if (hdr_count < 8) frame_chan = {frame_chan[23:0], b};
            hdr_count++;
            if (hdr_count < cfd_pkg::HeaderBytes) return 1'b0;
            hdr_count = 5'd0;
            if (frame_len == 32'd0 || frame_len > length_limit()) begin
                halted = 1'b1;
                res.ev = cfd_pkg::EV_BAD_LEN;
                return 1'b1;
            end
            body_left   = frame_len;
            ctrl_count  = 3'd0;
            ctrl_tag_ok = 1'b0;
            ctrl_cmd    = 32'd0;
            in_body     = 1'b1;
            return 1'b0;
        end

        body_left--;
        done = (body_left == 32'd0);
        if (done) in_body = 1'b0;

        // control channel wins even when it is also the stream channel
        if (frame_chan == cfd_pkg::CtrlChannel) begin
            if (ctrl_count == 3'd0) begin
                ctrl_tag_ok = (b == cfd_pkg::TagLong);
                ctrl_count  = 3'd1;
            end else if (ctrl_count < 3'd5) begin
                ctrl_cmd = {ctrl_cmd[23:0], b};
                ctrl_count++;
            end
            if (!done) return 1'b0;
            cmd = (ctrl_count == 3'd5 && ctrl_tag_ok) ? ctrl_cmd : 32'd0;
            if (cmd == 32'd0) begin
                halted = 1'b1;
                res.ev = cfd_pkg::EV_SERVER;
                return 1'b1;
            end
            if (cmd == cfd_pkg::CmdKilled) begin
                halted = 1'b1;
                res.ev = cfd_pkg::EV_KILLED;
                return 1'b1;
            end
            return 1'b0;
        end

        if (frame_chan == stream_chan) begin
            res.data = b;
            res.last = done;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic int unsigned draw_gap(input bit idle_on);
        return idle_on ? $urandom_range(0, 17) : 0;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // link byte driver
    int unsigned send_gap = 0;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid       <= 1'b0;
            in_if.stream_byte <= 8'h00;
        end else if (issued_bytes == accepted_bytes) begin
            if (send_gap > 0) begin
                send_gap--;
                in_if.valid       <= 1'b0;
                in_if.stream_byte <= 8'($urandom);
            end else if (pending_bytes.size() > 0) begin
                in_if.stream_byte <= pending_bytes.pop_front();
                in_if.valid       <= 1'b1;
                issued_bytes++;
                send_gap = draw_gap(in_idle_on);
            end else begin
                in_if.valid       <= 1'b0;
                in_if.stream_byte <= 8'($urandom);
            end
        end
    end

    // result receiver with random stalls
    int unsigned stall_left      = 0;
    int unsigned results_handled = 0;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (results_handled != results_seen) begin
                results_handled = results_seen;
                stall_left      = draw_gap(out_idle_on);
            end
            if (stall_left > 0) begin
                stall_left--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    // monitor: checks results, tracks register writes, predicts accepted bytes
    always @(posedge i_clk) begin
        t_deframe_result want;
        t_deframe_result got;
        if (i_rst_n) begin
            if (out_if.valid && out_if.ready) begin
                results_seen++;
                got = '{out_if.data_byte, out_if.last_in_frame, out_if.event_res};
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result data %02h last %0d event %0d",
                             $time, got.data, got.last, got.ev);
                    fault_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (got.data !== want.data || got.last !== want.last ||
                        got.ev !== want.ev) begin
                        $display("%0t: mismatch: expected %02h/%0d/%0d got %02h/%0d/%0d",
                                 $time, want.data, want.last, want.ev,
                                 got.data, got.last, got.ev);
                        fault_count++;
                    end
                end
            end
            if (i_cfg_we) begin
                if (i_cfg_index == cfd_pkg::CFG_STREAM_CHANNEL) stream_chan = i_cfg_data;
                else max_len = i_cfg_data[cfd_pkg::MaxLengthBits-1:0];
            end
            if (in_if.valid && in_if.ready) begin
                accepted_bytes++;
                if (deframe_byte(in_if.stream_byte, want)) expected_results.push_back(want);
            end
        end
    end

    task automatic write_reg(input cfd_pkg::t_cfg_index idx, input logic [31:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        i_cfg_data  <= $urandom;
    endtask

    task automatic push_header(input logic [31:0] len, input logic [31:0] chan);
        for (int i = 3; i >= 0; i--) pending_bytes.push_back(len[8*i +: 8]);
        for (int i = 3; i >= 0; i--) pending_bytes.push_back(chan[8*i +: 8]);
        repeat (12) pending_bytes.push_back(8'($urandom));
    endtask

    // body: tag byte, then the command big-endian, then filler
    task automatic push_body(input int unsigned len, input logic [7:0] tag,
                             input logic [31:0] cmd);
        for (int unsigned i = 0; i < len; i++) begin
            if (i == 0) pending_bytes.push_back(tag);
            else if (i < 5) pending_bytes.push_back(cmd[8*(4-i) +: 8]);
            else pending_bytes.push_back(8'($urandom));
        end
    endtask

    // well-formed frame that cannot stop the block
    task automatic push_random_frame();
        logic [31:0] lim;
        logic [31:0] chan;
        logic [31:0] other;
        logic [31:0] cmd;
        int unsigned len;
        int unsigned cap;
        int unsigned pick;
        lim  = length_limit();
        cap  = (lim < 24) ? lim : 24;
        pick = $urandom_range(0, 15);
        if (pick == 0) len = (lim <= 300) ? lim : $urandom_range(100, 300);
        else if (pick < 3) len = $urandom_range(1, (lim < 300) ? lim : 300);
        else len = $urandom_range(1, cap);

        do begin
            other = $urandom_range(0, 1) ? (stream_chan ^ (32'd1 << $urandom_range(0, 31)))
                                         : 32'($urandom);
        end while (other == stream_chan || other == cfd_pkg::CtrlChannel);

        pick = $urandom_range(0, 9);
        if (pick < 5) chan = stream_chan;
        else if (pick < 7) chan = cfd_pkg::CtrlChannel;
        else chan = other;
        if (chan == cfd_pkg::CtrlChannel && lim < 5) chan = other;

        if (chan == cfd_pkg::CtrlChannel) begin
            if (len < 5) len = $urandom_range(5, cap);
            case ($urandom_range(0, 3))
                0: cmd = 32'hFFFF_FFFF;
                1: cmd = cfd_pkg::CmdKilled << 8;
                2: cmd = cfd_pkg::CmdKilled | 32'h0100_0000;
                default: begin
                    cmd = $urandom;
                    if (cmd == 32'd0 || cmd == cfd_pkg::CmdKilled) cmd = 32'd1;
                end
            endcase
            push_header(len, chan);
            push_body(len, cfd_pkg::TagLong, cmd);
        end else begin
            push_header(len, chan);
            push_body(len, 8'($urandom), 32'($urandom));
        end
    endtask

    // holds the sender until the block has drained
    task automatic wait_quiet();
        int unsigned waited;
        waited = 0;
        do begin
            @(posedge i_clk);
            #1;
        end while (pending_bytes.size() != 0 || issued_bytes != accepted_bytes);
        while (expected_results.size() != 0 && waited < 500) begin
            @(posedge i_clk);
            #1;
            waited++;
        end
        if (expected_results.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time,
                     expected_results.size());
            fault_count++;
            expected_results.delete();
        end
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        logic [31:0] len;
        logic [7:0]  tag;
        int unsigned kind;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = cfd_pkg::CFG_STREAM_CHANNEL;
        i_cfg_data  = '0;

        // two-byte frame on the reset channel with payload extremes
        push_header(32'd2, 32'd0);
        push_body(2, 8'hFF, 32'h0000_0000);

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        wait_quiet();

        for (int p = 0; p < 8; p++) begin
            case (p)
                0: write_reg(cfd_pkg::CFG_STREAM_CHANNEL, $urandom);
                1: write_reg(cfd_pkg::CFG_STREAM_CHANNEL, 32'hFFFF_FFFE);
                2: write_reg(cfd_pkg::CFG_STREAM_CHANNEL, 32'd0);
                3: write_reg(cfd_pkg::CFG_STREAM_CHANNEL, cfd_pkg::CtrlChannel);
                default: write_reg(cfd_pkg::CFG_STREAM_CHANNEL, $urandom);
            endcase
            // bits above the register width must be dropped
            case (p)
                0: write_reg(cfd_pkg::CFG_MAX_LENGTH, 32'hDEAD_0000);
                1: write_reg(cfd_pkg::CFG_MAX_LENGTH, 32'd1);
                2: write_reg(cfd_pkg::CFG_MAX_LENGTH, cfd_pkg::AbsMaxLen);
                3: write_reg(cfd_pkg::CFG_MAX_LENGTH, 32'h0007_FFFF);
                4: write_reg(cfd_pkg::CFG_MAX_LENGTH, 32'd5);
                default: write_reg(cfd_pkg::CFG_MAX_LENGTH,
                                   ($urandom & 32'hFFF8_0000) | $urandom_range(1, 64));
            endcase
            in_idle_on  = !(p == 2 || p == 6);
            out_idle_on = !(p == 2 || p == 5);
            while (pending_bytes.size() < 240) push_random_frame();
            wait_quiet();
        end

        // one terminating error, then bytes that the halted block must swallow
        in_idle_on  = 1'b1;
        out_idle_on = 1'b1;
        write_reg(cfd_pkg::CFG_MAX_LENGTH, cfd_pkg::AbsMaxLen);
        kind = $urandom_range(0, 7);
        if (kind == 3) write_reg(cfd_pkg::CFG_MAX_LENGTH, 32'd0);
        else repeat (3) push_random_frame();
        case (kind)
            0: push_header(32'd0, $urandom);
            1: push_header(length_limit() + 32'd1, stream_chan);
            2: push_header(32'h8000_0000 | $urandom, stream_chan);
            3: push_header($urandom_range(1, 20), stream_chan);
            4: begin
                len = $urandom_range(1, 4);
                push_header(len, cfd_pkg::CtrlChannel);
                push_body(len, cfd_pkg::TagLong, $urandom | 32'd1);
            end
            5: begin
                len = $urandom_range(5, 12);
                tag = 8'($urandom);
                if (tag == cfd_pkg::TagLong) tag = ~cfd_pkg::TagLong;
                push_header(len, cfd_pkg::CtrlChannel);
                push_body(len, tag, $urandom | 32'd1);
            end
            6: begin
                len = $urandom_range(5, 12);
                push_header(len, cfd_pkg::CtrlChannel);
                push_body(len, cfd_pkg::TagLong, 32'd0);
            end
            default: begin
                len = $urandom_range(5, 12);
                push_header(len, cfd_pkg::CtrlChannel);
                push_body(len, cfd_pkg::TagLong, cfd_pkg::CmdKilled);
            end
        endcase
        push_header(32'd4, stream_chan);
        push_body(4, 8'($urandom), 32'($urandom));
        repeat (20) pending_bytes.push_back(8'($urandom));
        wait_quiet();

        repeat (8) @(posedge i_clk);
        if (fault_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("%0t: timeout", $time);
        $display("== FAIL ==");
        $finish;
    end

endmodule
